### rtl/core/fxlms_pkg.sv
// fxlms_pkg: shared types and constants for the FxLMS filter core.
// No dependencies.
`default_nettype none
package fxlms_pkg;
  localparam int FILTER_TAPS_DEF = 32;
  localparam int SEC_TAPS_DEF    = 4;
  localparam int NUM_SEC_REGS    = 4;
  localparam logic [15:0] STEP_SIZE_RST = 16'd66;

  typedef enum logic [2:0] {
    REG_STEP = 3'd0, REG_SEC0 = 3'd1, REG_SEC1 = 3'd2, REG_SEC2 = 3'd3, REG_SEC3 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] ref_sample;
    logic signed [15:0] desired_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] anti_noise;
    logic signed [15:0] error_sample;
  } out_item_t;

  // control from the sequencer to the cell row
  typedef struct packed {
    logic shift_x;  // advance the samples one place
    logic shift_w;  // advance the weights one place
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_ERR, ST_MUE, ST_UPD, ST_OUT
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/fxlms_cell.sv
// fxlms_cell: one tap of the rotating row: history sample and weight.
// Depends on fxlms_pkg.
`default_nettype none
module fxlms_cell import fxlms_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_ctl_t          ctl,
  input  wire logic signed [15:0] x_in,
  input  wire logic signed [31:0] w_in,
  output logic signed [15:0]      x_out,
  output logic signed [31:0]      w_out
);
  logic signed [15:0] x_r;
  logic signed [31:0] w_r;

  // take neighbor data on each shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      w_r <= '0;
    end else begin
      if (ctl.shift_x) x_r <= x_in;
      if (ctl.shift_w) w_r <= w_in;
    end
  end

  assign x_out = x_r;
  assign w_out = w_r;
endmodule
`default_nettype wire

### rtl/core/fxlms_adaptive_filter_core.sv
// FxLMS adaptive filter core: one item at a time, through a tap-serial MAC
// pass and a weight update pass around the rotating cell row.
// The result is offered once the update pass is done; the next item is
// taken the cycle after the result leaves.
// Synchronous active-low reset zeroes history and weights and restores
// register defaults; items are taken from the first cycle after reset.
`default_nettype none
module fxlms_adaptive_filter_core import fxlms_pkg::*; #(
  parameter int FILTER_TAPS = FILTER_TAPS_DEF,
  parameter int SEC_TAPS    = SEC_TAPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int CW = $clog2(FILTER_TAPS + 1);
  localparam int AW = 48 + $clog2(FILTER_TAPS + 1);

  logic [15:0] step_r;
  logic signed [15:0] sec_r [NUM_SEC_REGS];
  reg_idx_t ridx;
  assign ridx = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_SIZE_RST;
      for (int k = 0; k < NUM_SEC_REGS; k++) sec_r[k] <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_STEP: step_r   <= cfg_pwdata[15:0];
        REG_SEC0: sec_r[0] <= cfg_pwdata[15:0];
        REG_SEC1: sec_r[1] <= cfg_pwdata[15:0];
        REG_SEC2: sec_r[2] <= cfg_pwdata[15:0];
        REG_SEC3: sec_r[3] <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_STEP: cfg_prdata = {16'd0, step_r};
        REG_SEC0: cfg_prdata = {{16{sec_r[0][15]}}, sec_r[0]};
        REG_SEC1: cfg_prdata = {{16{sec_r[1][15]}}, sec_r[1]};
        REG_SEC2: cfg_prdata = {{16{sec_r[2][15]}}, sec_r[2]};
        REG_SEC3: cfg_prdata = {{16{sec_r[3][15]}}, sec_r[3]};
        default:  cfg_prdata = '0;
      endcase
    end
  end

  // sequencer and datapath signals
  state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [15:0] d_r, y_r, e_r;
  logic signed [AW-1:0] acc_r;
  logic signed [31:0] mue_r;
  logic signed [33:0] f_r;
  logic signed [33:0] fx_nxt;
  logic signed [15:0] e_nxt;
  logic signed [31:0] mue_nxt;
  logic signed [47:0] mprod;
  logic signed [65:0] wprod;
  logic signed [65:0] wdlt;
  logic signed [66:0] wsum;
  logic signed [31:0] w_upd;
  logic signed [15:0] win [NUM_SEC_REGS];
  cell_ctl_t ctl;

  logic signed [15:0] xc [FILTER_TAPS+1];
  logic signed [31:0] wc [FILTER_TAPS+1];

  // ring feed: head takes tail, the new sample on load, the new weight on update
  assign xc[0] = (st_r == ST_IDLE) ? in_data.ref_sample : xc[FILTER_TAPS];
  assign wc[0] = (st_r == ST_UPD) ? w_upd : wc[FILTER_TAPS];

  for (genvar g = 0; g < FILTER_TAPS; g++) begin : g_cell
    fxlms_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .x_in(xc[g]), .w_in(wc[g]),
      .x_out(xc[g+1]), .w_out(wc[g+1]));
  end

  // The load moves only the samples, so cell k holds history k beside weight k.
  // Each pass rotates both FILTER_TAPS places; after t shifts the tail cell
  // holds tap FILTER_TAPS-1-t and the cells in front of it the lower taps.

  // sample window for the filtered reference: at home (tap FILTER_TAPS-1)
  // before the update pass, one tap ahead of the tail during it
  for (genvar j = 0; j < NUM_SEC_REGS; j++) begin : g_win
    if (j < FILTER_TAPS - 1) begin : g_both
      assign win[j] = (st_r == ST_MUE) ? xc[FILTER_TAPS-j] : xc[FILTER_TAPS-1-j];
    end else if (j < FILTER_TAPS) begin : g_home
      assign win[j] = (st_r == ST_MUE) ? xc[FILTER_TAPS-j] : 16'sd0;
    end else begin : g_none
      assign win[j] = 16'sd0;
    end
  end

  // filtered reference for the next tap to update; skip taps below index zero
  always_comb begin
    int lim;
    logic signed [33:0] a;
    if (st_r == ST_MUE) lim = FILTER_TAPS - 1;
    else lim = FILTER_TAPS - 2 - int'(cnt_r);
    a = '0;
    for (int j = 0; j < NUM_SEC_REGS; j++) begin
      if (j < SEC_TAPS && j <= lim) a = a + 34'(win[j]) * 34'(sec_r[j]);
    end
    fx_nxt = a;
  end

  // error and step times error
  assign e_nxt   = sat16(64'(d_r) - 64'(y_r));
  assign mue_nxt = 32'($signed({1'b0, step_r})) * 32'(e_nxt);

  // weight step: floor shift by 33, saturate
  always_comb begin
    wprod = 66'(mue_r) * 66'(f_r);
    wdlt  = wprod >>> 33;
    wsum  = 67'(wc[FILTER_TAPS]) + 67'(wdlt);
    if (wsum > 67'sh7fffffff) w_upd = 32'sh7fffffff;
    else if (wsum < -67'sh80000000) w_upd = 32'sh80000000;
    else w_upd = wsum[31:0];
  end

  // MAC product at the ring tail
  assign mprod = 48'(wc[FILTER_TAPS]) * 48'(xc[FILTER_TAPS]);

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.shift_x = 1'b1;
          st_nxt  = ST_MAC;
          cnt_nxt = '0;
        end
      end
      ST_MAC: begin
        ctl.shift_x = 1'b1;
        ctl.shift_w = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(FILTER_TAPS - 1)) begin
          st_nxt  = ST_ERR;
          cnt_nxt = '0;
        end
      end
      ST_ERR: st_nxt = ST_MUE;
      ST_MUE: begin
        st_nxt  = ST_UPD;
        cnt_nxt = '0;
      end
      ST_UPD: begin
        ctl.shift_x = 1'b1;
        ctl.shift_w = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(FILTER_TAPS - 1)) begin
          st_nxt  = ST_OUT;
          cnt_nxt = '0;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // accumulate, then form output, error and step product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r   <= '0;
      y_r   <= '0;
      e_r   <= '0;
      acc_r <= '0;
      mue_r <= '0;
      f_r   <= '0;
    end else begin
      if (st_r == ST_IDLE) begin
        acc_r <= '0;
        if (in_valid) d_r <= in_data.desired_sample;
      end else if (st_r == ST_MAC) begin
        acc_r <= acc_r + AW'(mprod);
      end
      if (st_r == ST_ERR) y_r <= sat16(64'(acc_r >>> 28));
      if (st_r == ST_MUE) begin
        e_r   <= e_nxt;
        mue_r <= mue_nxt;
      end
      if (st_r == ST_MUE || st_r == ST_UPD) f_r <= fx_nxt;
    end
  end

  assign out_data.anti_noise   = y_r;
  assign out_data.error_sample = e_r;
endmodule
`default_nettype wire
